>>> hw/rtl/cbag_pkg.sv
`default_nettype none

package cbag_pkg;

  // Access codes on the opcode port. Writes mirror the reads one to eight.
  localparam logic [4:0] OP_FETCH        = 5'd0;
  localparam logic [4:0] OP_LAST_READ    = 5'd8;
  localparam logic [4:0] OP_FIRST_WRITE  = 5'd9;
  localparam logic [4:0] OP_LAST_WRITE   = 5'd16;
  localparam logic [4:0] OP_WRITE_OFFSET = 5'd8;

  typedef enum logic [3:0] {
    KIND_FETCH,
    KIND_PULL,
    KIND_NPULL,
    KIND_ABS,
    KIND_LONG,
    KIND_DBANK,
    KIND_PBANK,
    KIND_DP,
    KIND_SR,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  write;
  } access_t;

  typedef struct packed {
    access_t     access;
    logic [23:0] operand_address;
    logic [7:0]  write_value;
    logic [23:0] program_counter;
    logic [15:0] stack_pointer;
    logic [15:0] direct_page;
    logic [7:0]  data_bank;
    logic        emulation_flag;
  } item_t;

  typedef struct packed {
    logic [23:0] bus_address;
    logic        bus_write;
    logic [7:0]  bus_data;
    logic [23:0] next_program_counter;
    logic [15:0] next_stack_pointer;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbag_input_stage.sv
`default_nettype none

module cbag_input_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [4:0]       opcode,
  input  wire logic [23:0]      operand_address,
  input  wire logic [7:0]       write_value,
  input  wire logic [23:0]      program_counter,
  input  wire logic [15:0]      stack_pointer,
  input  wire logic [15:0]      direct_page,
  input  wire logic [7:0]       data_bank,
  input  wire logic             emulation_flag,
  output logic                  item_valid,
  output cbag_pkg::item_t       item
);

  cbag_pkg::access_t access_next;
  logic [4:0]        code;

  // Write codes fold onto the read kinds; anything past the last write is unused.
  always_comb begin
    access_next.write = 1'b0;
    code = opcode;
    if (opcode inside {[cbag_pkg::OP_FIRST_WRITE:cbag_pkg::OP_LAST_WRITE]}) begin
      access_next.write = 1'b1;
      code = opcode - cbag_pkg::OP_WRITE_OFFSET;
    end
    if (opcode inside {[cbag_pkg::OP_FETCH:cbag_pkg::OP_LAST_WRITE]}) begin
      access_next.kind = cbag_pkg::kind_t'(code[3:0]);
    end else begin
      access_next.kind = cbag_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.access          <= access_next;
      item.operand_address <= operand_address;
      item.write_value     <= write_value;
      item.program_counter <= program_counter;
      item.stack_pointer   <= stack_pointer;
      item.direct_page     <= direct_page;
      item.data_bank       <= data_bank;
      item.emulation_flag  <= emulation_flag;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbag_addr_unit.sv
`default_nettype none

module cbag_addr_unit (
  input  cbag_pkg::item_t   item,
  output cbag_pkg::result_t result
);

  logic        native;
  logic [15:0] sp_step;
  logic [7:0]  sp_low;
  logic [15:0] dp_sum;
  logic [15:0] sr_sum;
  logic [23:0] db_sum;
  logic [23:0] pc_inc;

  always_comb begin
    native = (item.access.kind == cbag_pkg::KIND_NPULL);
    // Pushes post-decrement and pulls pre-increment the stack pointer.
    if (item.access.write) begin
      sp_low  = item.stack_pointer[7:0] - 8'd1;
      sp_step = item.stack_pointer - 16'd1;
    end else begin
      sp_low  = item.stack_pointer[7:0] + 8'd1;
      sp_step = item.stack_pointer + 16'd1;
    end
    // In emulation mode the ordinary stack stays within its page.
    if (item.emulation_flag && !native) begin
      sp_step = {item.stack_pointer[15:8], sp_low};
    end
    dp_sum = item.direct_page + item.operand_address[15:0];
    sr_sum = item.stack_pointer + item.operand_address[15:0];
    db_sum = {item.data_bank, 16'h0000} + item.operand_address;
    pc_inc = item.program_counter + 24'd1;
  end

  always_comb begin
    result.bus_write            = item.access.write;
    result.bus_data             = item.access.write ? item.write_value : 8'h00;
    result.bus_address          = 24'h000000;
    result.next_program_counter = item.program_counter;
    result.next_stack_pointer   = item.stack_pointer;
    case (item.access.kind)
      cbag_pkg::KIND_FETCH: begin
        result.bus_address          = item.program_counter;
        result.next_program_counter = pc_inc;
      end
      cbag_pkg::KIND_PULL, cbag_pkg::KIND_NPULL: begin
        result.next_stack_pointer = sp_step;
        result.bus_address = item.access.write ? {8'h00, item.stack_pointer}
                                               : {8'h00, sp_step};
      end
      cbag_pkg::KIND_ABS: begin
        result.bus_address = {8'h00, item.operand_address[15:0]};
      end
      cbag_pkg::KIND_LONG: begin
        result.bus_address = item.operand_address;
      end
      cbag_pkg::KIND_DBANK: begin
        result.bus_address = db_sum;
      end
      cbag_pkg::KIND_PBANK: begin
        result.bus_address = {item.program_counter[23:16], item.operand_address[15:0]};
      end
      cbag_pkg::KIND_DP: begin
        // A page-aligned direct page wraps within its page in emulation mode.
        if (item.emulation_flag && item.direct_page[7:0] == 8'h00) begin
          result.bus_address = {8'h00, item.direct_page[15:8], dp_sum[7:0]};
        end else begin
          result.bus_address = {8'h00, dp_sum};
        end
      end
      cbag_pkg::KIND_SR: begin
        result.bus_address = {8'h00, sr_sum};
      end
      default: begin
        result.bus_address = 24'h000000;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/cpu_bus_address_generator.sv
// Each access passes through the input register, then the result register, and
// its result is strobed by done for exactly one cycle.
// Throughput: one access per cycle; busy is never raised.
// Reset: synchronous, active-high rst clears the stage valid bits and done.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module cpu_bus_address_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  opcode,
  input  wire logic [23:0] operand_address,
  input  wire logic [7:0]  write_value,
  input  wire logic [23:0] program_counter,
  input  wire logic [15:0] stack_pointer,
  input  wire logic [15:0] direct_page,
  input  wire logic [7:0]  data_bank,
  input  wire logic        emulation_flag,
  output logic             done,
  output logic [23:0]      bus_address,
  output logic             bus_write,
  output logic [7:0]       bus_data,
  output logic [23:0]      next_program_counter,
  output logic [15:0]      next_stack_pointer
);

  logic              accept;
  logic              item_valid;
  cbag_pkg::item_t   item;
  cbag_pkg::result_t result;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cbag_input_stage u_input_stage (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .opcode          (opcode),
    .operand_address (operand_address),
    .write_value     (write_value),
    .program_counter (program_counter),
    .stack_pointer   (stack_pointer),
    .direct_page     (direct_page),
    .data_bank       (data_bank),
    .emulation_flag  (emulation_flag),
    .item_valid      (item_valid),
    .item            (item)
  );

  cbag_addr_unit u_addr_unit (
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      bus_address          <= result.bus_address;
      bus_write            <= result.bus_write;
      bus_data             <= result.bus_data;
      next_program_counter <= result.next_program_counter;
      next_stack_pointer   <= result.next_stack_pointer;
    end
  end

`ifndef SYNTH
  a_done_follows_stage: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done)
    else $error("stage beat did not produce a result");

  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !bus_write) |-> (bus_data == 8'h00))
    else $error("read beat drives nonzero data");

  a_write_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.access.write) |=>
      (next_program_counter == $past(item.program_counter)))
    else $error("write beat changed the program counter");

  a_emu_stack_page: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.emulation_flag && item.access.kind == cbag_pkg::KIND_PULL) |=>
      (next_stack_pointer[15:8] == $past(item.stack_pointer[15:8])))
    else $error("emulation stack left its page");
`endif

endmodule

`default_nettype wire
